// ===== hw/rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key/value cache
// Sizes of the entry store, opcode codes, controller states, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Entry store geometry
  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W      = IDX_W;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);

  // Capacity register
  localparam int              CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Stream payload widths
  localparam int IN_TDATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;

  // Request kinds
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture request, restart scan
    logic scan_step;  // read the entry at the scan index, advance
    logic commit;     // update entries, load result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic idx_last;   // scan index points at the last entry
  } dp_stat_t;

endpackage

// ===== hw/rtl/lkvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkvc_ctrl: request sequencer of the LRU key/value cache
// Accepts one request, steps the datapath through the entry scan, and
// commits once the result register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lkvc_pkg::dp_stat_t   stat_i,
  output lkvc_pkg::ctrl_cmd_t  cmd_o
);

  lkvc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             res_free;

  // Result register can take a new result this cycle
  assign res_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lkvc_pkg::ST_SCAN;
      end
      lkvc_pkg::ST_SCAN: begin
        if (stat_i.idx_last) state_d = lkvc_pkg::ST_DRAIN;
      end
      lkvc_pkg::ST_DRAIN: begin
        state_d = lkvc_pkg::ST_COMMIT;
      end
      lkvc_pkg::ST_COMMIT: begin
        if (res_free) state_d = lkvc_pkg::ST_IDLE;
      end
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      lkvc_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      lkvc_pkg::ST_DRAIN: begin
        cmd_o = '0;
      end
      lkvc_pkg::ST_COMMIT: begin
        cmd_o.commit = res_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // Set result valid on commit, drop it when the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkvc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/lkvc_datapath.sv =====
// ----------------------------------------------------------------------------
// lkvc_datapath: entry store, scan and update logic of the LRU cache
// Keys and values sit in memories read one entry a cycle. Valid marks and
// recency ranks are flops updated in parallel at commit.
// ----------------------------------------------------------------------------
module lkvc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkvc_pkg::ctrl_cmd_t               cmd_i,
  output lkvc_pkg::dp_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  logic                              in_opcode_i,
  input  logic signed [lkvc_pkg::KEY_BITS-1:0]   in_key_i,
  input  logic signed [lkvc_pkg::VALUE_BITS-1:0] in_value_i,
  output logic                              res_hit_o,
  output logic signed [lkvc_pkg::VALUE_BITS-1:0] res_value_o,
  output logic                              res_evicted_o,
  output logic signed [lkvc_pkg::KEY_BITS-1:0]   res_evicted_key_o
);

  localparam int N  = lkvc_pkg::MAX_ENTRIES;
  localparam int KW = lkvc_pkg::KEY_BITS;
  localparam int VW = lkvc_pkg::VALUE_BITS;
  localparam int IW = lkvc_pkg::IDX_W;
  localparam int RW = lkvc_pkg::RANK_W;
  localparam int OW = lkvc_pkg::OCC_W;
  localparam int CW = lkvc_pkg::CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

  // Entry store
  logic [KW-1:0] key_mem [N];
  logic [VW-1:0] val_mem [N];
  logic [N-1:0]  valid_q, valid_d;
  logic [RW-1:0] rank_q [N];
  logic [RW-1:0] rank_d [N];
  logic [OW-1:0] occ_q, occ_d;
  logic [CW-1:0] cap_q;

  // Request registers
  logic          op_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;

  // Scan pipeline
  logic [IW-1:0] idx_q;
  logic          eval_q;
  logic [IW-1:0] eval_idx_q;
  logic [KW-1:0] rd_key_q;
  logic [VW-1:0] rd_val_q;

  // Scan findings
  logic          match_q;
  logic [IW-1:0] match_idx_q;
  logic [RW-1:0] match_rank_q;
  logic [VW-1:0] match_val_q;
  logic          vict_q;
  logic [IW-1:0] vict_idx_q;
  logic [RW-1:0] vict_rank_q;
  logic [KW-1:0] vict_key_q;
  logic          free_q;
  logic [IW-1:0] free_idx_q;

  // Commit decisions
  logic [OW-1:0] eff_cap;
  logic          is_put;
  logic          do_evict;
  logic          do_insert;
  logic [IW-1:0] slot_idx;
  logic          mem_we_key;
  logic          mem_we_val;
  logic [IW-1:0] mem_wr_idx;

  // Result registers
  logic          res_hit_q;
  logic [VW-1:0] res_value_q;
  logic          res_evicted_q;
  logic [KW-1:0] res_evicted_key_q;

  assign stat_o.idx_last = (idx_q == LAST_IDX);

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp capacity to one..MAX_ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = OW'(1);
    end else if (32'(cap_q) > N) begin
      eff_cap = OW'(N);
    end else begin
      eff_cap = OW'(cap_q);
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= in_opcode_i;
      key_q <= in_key_i;
      val_q <= in_value_i;
    end
  end

  // Advance the scan index and the evaluation stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      eval_q     <= 1'b0;
      eval_idx_q <= '0;
    end else begin
      eval_q     <= cmd_i.scan_step;
      eval_idx_q <= idx_q;
      if (cmd_i.load_in) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
      end
    end
  end

  // Read one entry per cycle
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[idx_q];
    rd_val_q <= val_mem[idx_q];
  end

  // Record first match, least recent entry and first free entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      vict_q  <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.load_in) begin
      match_q <= 1'b0;
      vict_q  <= 1'b0;
      free_q  <= 1'b0;
    end else if (eval_q) begin
      if (valid_q[eval_idx_q] && rd_key_q == key_q && !match_q) begin
        match_q <= 1'b1;
      end
      if (valid_q[eval_idx_q] && (!vict_q || rank_q[eval_idx_q] > vict_rank_q)) begin
        vict_q <= 1'b1;
      end
      if (!valid_q[eval_idx_q] && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_q) begin
      if (valid_q[eval_idx_q] && rd_key_q == key_q && !match_q) begin
        match_idx_q  <= eval_idx_q;
        match_rank_q <= rank_q[eval_idx_q];
        match_val_q  <= rd_val_q;
      end
      if (valid_q[eval_idx_q] && (!vict_q || rank_q[eval_idx_q] > vict_rank_q)) begin
        vict_idx_q  <= eval_idx_q;
        vict_rank_q <= rank_q[eval_idx_q];
        vict_key_q  <= rd_key_q;
      end
      if (!valid_q[eval_idx_q] && !free_q) begin
        free_idx_q <= eval_idx_q;
      end
    end
  end

  // Decide the outcome of the request
  assign is_put    = (op_q == lkvc_pkg::OP_PUT);
  assign do_evict  = is_put && !match_q && (occ_q >= eff_cap) && vict_q;
  assign slot_idx  = do_evict ? vict_idx_q : free_idx_q;
  assign do_insert = is_put && !match_q && (do_evict || free_q);

  assign mem_we_key = cmd_i.commit && do_insert;
  assign mem_we_val = cmd_i.commit && (do_insert || (is_put && match_q));
  assign mem_wr_idx = match_q ? match_idx_q : slot_idx;

  // Write key and value memories
  always_ff @(posedge clk_i) begin
    if (mem_we_key) begin
      key_mem[mem_wr_idx] <= key_q;
    end
    if (mem_we_val) begin
      val_mem[mem_wr_idx] <= val_q;
    end
  end

  // Update valid marks, ranks and occupancy
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < N; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.commit) begin
      if (match_q) begin
        // age entries more recent than the hit, hit becomes most recent
        for (int i = 0; i < N; i++) begin
          if (IW'(i) == match_idx_q) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && rank_q[i] < match_rank_q) begin
            rank_d[i] = rank_q[i] + RW'(1);
          end
        end
      end else if (do_insert) begin
        // age every other entry, new entry becomes most recent
        for (int i = 0; i < N; i++) begin
          if (IW'(i) == slot_idx) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + RW'(1);
          end
        end
        if (!do_evict) begin
          occ_d = occ_q + OW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_hit_q         <= match_q;
      res_value_q       <= is_put ? '0 : (match_q ? match_val_q : '1);
      res_evicted_q     <= do_evict;
      res_evicted_key_q <= do_evict ? vict_key_q : '0;
    end
  end

  assign res_hit_o         = res_hit_q;
  assign res_value_o       = res_value_q;
  assign res_evicted_o     = res_evicted_q;
  assign res_evicted_key_o = res_evicted_key_q;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
// Top level: stream ports, capacity register port, controller and datapath.
// ----------------------------------------------------------------------------
// Each request is a get or a put and yields exactly one result. The request is
// captured at the accepting edge, then the scan state steps the single read
// port of the key/value memories over every entry, the drain state evaluates
// the last registered read, and the commit state updates ranks and valid
// marks and loads the result register. Commit waits while an earlier result
// is still held on the output. The controller goes back to idle after commit,
// so no new request is accepted before the current one has committed. A new
// request is taken while an earlier result still waits on the output. Valid
// marks are cleared by reset, so the cache is usable right after reset. Write
// the capacity only while no request is in flight.
module lru_key_value_cache (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // capacity register
  input  logic                              cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lkvc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // lookup_key, write_value
  input  logic                              s_axis_tuser,  // opcode
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lkvc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // read_value, evicted_key
  output logic [1:0]                        m_axis_tuser   // hit, evicted
);

  localparam int KW = lkvc_pkg::KEY_BITS;
  localparam int VW = lkvc_pkg::VALUE_BITS;

  lkvc_pkg::ctrl_cmd_t cmd;
  lkvc_pkg::dp_stat_t  stat;

  logic                 res_hit;
  logic signed [VW-1:0] res_value;
  logic                 res_evicted;
  logic signed [KW-1:0] res_evicted_key;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lkvc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_opcode_i       (s_axis_tuser),
    .in_key_i          (s_axis_tdata[KW-1:0]),
    .in_value_i        (s_axis_tdata[KW+VW-1:KW]),
    .res_hit_o         (res_hit),
    .res_value_o       (res_value),
    .res_evicted_o     (res_evicted),
    .res_evicted_key_o (res_evicted_key)
  );

  // Pack the result
  assign m_axis_tdata = lkvc_pkg::OUT_TDATA_W'({res_evicted_key, res_value});
  assign m_axis_tuser = {res_evicted, res_hit};

endmodule
